// ----- hw/rtl/otr_pkg.sv -----
package otr_pkg;

   localparam int SLOT_COUNT       = 128;
   localparam int MAX_RECORD_BYTES = 896;
   localparam int ID_LIMIT         = 62;
   localparam int MAX_RESULTS      = 64;

   localparam int AW   = $clog2(SLOT_COUNT);
   localparam int SW   = AW + 1;
   localparam int LW   = $clog2(MAX_RECORD_BYTES + 1);
   localparam int PAW  = $clog2(MAX_RECORD_BYTES);
   localparam int RCW  = $clog2(MAX_RESULTS * 14 + 1);
   localparam int BW   = (LW > RCW) ? LW : RCW;
   localparam int PSW  = $clog2((MAX_RECORD_BYTES + 6) / 7 + 1);
   localparam int CW   = 16;

   localparam logic [5:0] TAG_ID_MASK   = 6'h3f;
   localparam logic [7:0] TAG_NOT_FIRST = 8'h80;
   localparam logic [7:0] TAG_NOT_LAST  = 8'h40;

   localparam logic [1:0] FL_SINGLE = 2'b00;
   localparam logic [1:0] FL_LAST   = 2'b10;
   localparam logic [1:0] FL_MIDDLE = 2'b11;
   localparam logic [1:0] FL_FIRST  = 2'b01;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_READ    = 2'd1,
      OP_PROGRAM = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STAT_DATA      = 3'd0,
      STAT_NOT_FOUND = 3'd1,
      STAT_BAD_ID    = 3'd2,
      STAT_PROGRAMMED = 3'd3,
      STAT_PRESENT   = 3'd4,
      STAT_NO_SPACE  = 3'd5,
      STAT_TOO_LONG  = 3'd6
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_APPEND,
      ST_FIND_RD,
      ST_FIND_EV,
      ST_WALK_RD,
      ST_WALK_EV,
      ST_FDONE,
      ST_RD_INIT,
      ST_RD_RD,
      ST_RD_EV,
      ST_CMP_RD,
      ST_CMP_EV,
      ST_TOP_RD,
      ST_TOP_EV,
      ST_CHK,
      ST_WR_RD,
      ST_WR_EV,
      ST_WR_SLOT,
      ST_RESP
   } state_type;

endpackage

// ----- hw/rtl/otp_tagged_record_store.sv -----
// A raw load is taken while idle and busy never rises. A read scans slots and then returns
// bytes one at a time; a program buffers each chunk byte and, on the final chunk, scans
// slots (lookup and top-slot search), compares or writes bytes and writes slots. Throughput:
// one request at a time; busy drops in the cycle that presents the last result, or once a
// non-final chunk is buffered. Reset clears control state and marks every slot
// erased (all ones) through per-slot valid bits. Results are strobed and cannot stall.
module otp_tagged_record_store (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_opcode,
   input  logic [6:0]   req_slot_index,
   input  logic [63:0]  req_slot_word,
   input  logic [5:0]   req_record_id,
   input  logic [9:0]   req_request_size,
   input  logic [55:0]  req_chunk_data,
   input  logic [2:0]   req_chunk_bytes,
   input  logic         req_chunk_last,
   output logic         rsp_valid,
   output logic [2:0]   rsp_status,
   output logic [55:0]  rsp_payload_low,
   output logic [55:0]  rsp_payload_high,
   output logic [3:0]   rsp_byte_count,
   output logic         rsp_last
);

   otr_pkg::state_type state_ff, state_in;

   logic                    is_prog_ff, is_prog_in;
   logic [5:0]              id_ff, id_in;
   logic [9:0]              req_size_ff, req_size_in;
   logic [55:0]             cdata_ff, cdata_in;
   logic [2:0]              cbytes_ff, cbytes_in;
   logic                    clast_ff, clast_in;
   logic [2:0]              ai_ff, ai_in;
   logic [otr_pkg::LW-1:0]  len_ff, len_in;
   logic [2:0]              pos_ff, pos_in;
   logic [otr_pkg::PSW-1:0] pslots_ff, pslots_in;
   logic                    ovf_ff, ovf_in;
   logic [otr_pkg::SW-1:0]  s_ff, s_in;
   logic [otr_pkg::SW-1:0]  t_ff, t_in;
   logic [otr_pkg::SW-1:0]  n_ff, n_in;
   logic [otr_pkg::AW-1:0]  first_ff, first_in;
   logic                    found_ff, found_in;
   logic [otr_pkg::BW-1:0]  cnt_ff, cnt_in;
   logic [otr_pkg::BW-1:0]  b_ff, b_in;
   logic [2:0]              bp_ff, bp_in;
   logic [otr_pkg::AW-1:0]  sp_ff, sp_in;
   logic [3:0]              nb_ff, nb_in;
   logic [111:0]            buf_ff, buf_in;
   logic [otr_pkg::SW-1:0]  start_ff, start_in;
   logic [otr_pkg::PSW-1:0] k_ff, k_in;
   logic [55:0]             wrd_ff, wrd_in;
   otr_pkg::status_type     st_ff, st_in;
   logic [otr_pkg::SLOT_COUNT-1:0] vld_ff, vld_in;
   logic                    rd_vld_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [55:0] rsp_lo_ff, rsp_lo_in;
   logic [55:0] rsp_hi_ff, rsp_hi_in;
   logic [3:0]  rsp_cnt_ff, rsp_cnt_in;
   logic        rsp_last_ff, rsp_last_in;

   logic                   img_we;
   logic [otr_pkg::AW-1:0] img_waddr, img_raddr;
   logic [63:0]            img_wdata, img_q, img_word;
   logic                   pend_we;
   logic [otr_pkg::PAW-1:0] pend_waddr, pend_raddr;
   logic [7:0]             pend_wdata, pend_q;

   logic [7:0]             tag, ibyte, wbyte, ntag;
   logic [1:0]             fl;
   logic [otr_pkg::CW-1:0] n7, cmin;
   logic [111:0]           buf_nxt;
   logic                   accept;

   otr_ram #(.WIDTH(64), .DEPTH(otr_pkg::SLOT_COUNT)) u_img (
      .clock    (clock),
      .we       (img_we),
      .waddr    (img_waddr),
      .wdata    (img_wdata),
      .raddr    (img_raddr),
      .rdata_ff (img_q)
   );

   otr_ram #(.WIDTH(8), .DEPTH(otr_pkg::MAX_RECORD_BYTES)) u_pend (
      .clock    (clock),
      .we       (pend_we),
      .waddr    (pend_waddr),
      .wdata    (pend_wdata),
      .raddr    (pend_raddr),
      .rdata_ff (pend_q)
   );

   assign busy   = (state_ff != otr_pkg::ST_IDLE);
   assign accept = start && !busy;

   assign img_word = rd_vld_ff ? img_q : '1;
   assign tag      = img_word[63:56];
   assign fl       = tag[7:6];
   assign ibyte    = img_word[bp_ff*8 +: 8];
   assign n7       = (otr_pkg::CW'(n_ff) << 3) - otr_pkg::CW'(n_ff);
   assign pend_raddr = otr_pkg::PAW'(b_ff);

   always_comb begin
      unique case (state_ff)
         otr_pkg::ST_FIND_RD, otr_pkg::ST_TOP_RD: img_raddr = otr_pkg::AW'(s_ff);
         otr_pkg::ST_WALK_RD:                     img_raddr = otr_pkg::AW'(t_ff);
         default:                                 img_raddr = sp_ff;
      endcase
   end

   always_comb begin
      cmin = otr_pkg::CW'(req_size_ff);
      if (n7 < cmin) begin
         cmin = n7;
      end
      if (otr_pkg::CW'(otr_pkg::MAX_RESULTS * 14) < cmin) begin
         cmin = otr_pkg::CW'(otr_pkg::MAX_RESULTS * 14);
      end
   end

   always_comb begin
      ntag = {2'b00, id_ff};
      if (pslots_ff > otr_pkg::PSW'(1)) begin
         if (k_ff != '0) begin
            ntag = ntag | otr_pkg::TAG_NOT_FIRST;
         end
         if (k_ff != pslots_ff - otr_pkg::PSW'(1)) begin
            ntag = ntag | otr_pkg::TAG_NOT_LAST;
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      is_prog_in  = is_prog_ff;
      id_in       = id_ff;
      req_size_in = req_size_ff;
      cdata_in    = cdata_ff;
      cbytes_in   = cbytes_ff;
      clast_in    = clast_ff;
      ai_in       = ai_ff;
      len_in      = len_ff;
      pos_in      = pos_ff;
      pslots_in   = pslots_ff;
      ovf_in      = ovf_ff;
      s_in        = s_ff;
      t_in        = t_ff;
      n_in        = n_ff;
      first_in    = first_ff;
      found_in    = found_ff;
      cnt_in      = cnt_ff;
      b_in        = b_ff;
      bp_in       = bp_ff;
      sp_in       = sp_ff;
      nb_in       = nb_ff;
      buf_in      = buf_ff;
      start_in    = start_ff;
      k_in        = k_ff;
      wrd_in      = wrd_ff;
      st_in       = st_ff;
      vld_in      = vld_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_lo_in     = rsp_lo_ff;
      rsp_hi_in     = rsp_hi_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;
      img_we     = 1'b0;
      img_waddr  = otr_pkg::AW'(req_slot_index);
      img_wdata  = req_slot_word;
      pend_we    = 1'b0;
      pend_waddr = otr_pkg::PAW'(len_ff);
      pend_wdata = cdata_ff[ai_ff*8 +: 8];
      buf_nxt    = buf_ff;
      wbyte      = '0;

      unique case (state_ff)
         otr_pkg::ST_IDLE: begin
            if (accept) begin
               id_in       = req_record_id;
               req_size_in = req_request_size;
               cdata_in    = req_chunk_data;
               cbytes_in   = req_chunk_bytes;
               clast_in    = req_chunk_last;
               s_in        = otr_pkg::SW'(otr_pkg::SLOT_COUNT - 1);
               ai_in       = '0;
               unique case (otr_pkg::op_type'(req_opcode))
                  otr_pkg::OP_LOAD: begin
                     if (otr_pkg::CW'(req_slot_index) < otr_pkg::CW'(otr_pkg::SLOT_COUNT)) begin
                        img_we = 1'b1;
                        vld_in[otr_pkg::AW'(req_slot_index)] = 1'b1;
                     end
                  end
                  otr_pkg::OP_READ: begin
                     is_prog_in = 1'b0;
                     if (req_record_id > 6'(otr_pkg::ID_LIMIT)) begin
                        st_in    = otr_pkg::STAT_BAD_ID;
                        state_in = otr_pkg::ST_RESP;
                     end else begin
                        state_in = otr_pkg::ST_FIND_RD;
                     end
                  end
                  otr_pkg::OP_PROGRAM: begin
                     is_prog_in = 1'b1;
                     state_in   = otr_pkg::ST_APPEND;
                  end
                  default: begin
                  end
               endcase
            end
         end

         otr_pkg::ST_APPEND: begin
            if (ai_ff < cbytes_ff) begin
               ai_in = ai_ff + 3'd1;
               if (otr_pkg::CW'(len_ff) < otr_pkg::CW'(otr_pkg::MAX_RECORD_BYTES)) begin
                  pend_we = 1'b1;
                  len_in  = len_ff + otr_pkg::LW'(1);
                  if (pos_ff == 3'd0) begin
                     pslots_in = pslots_ff + otr_pkg::PSW'(1);
                  end
                  pos_in = (pos_ff == 3'd6) ? 3'd0 : pos_ff + 3'd1;
               end else begin
                  ovf_in = 1'b1;
               end
            end else if (!clast_ff) begin
               state_in = otr_pkg::ST_IDLE;
            end else if (id_ff > 6'(otr_pkg::ID_LIMIT)) begin
               st_in    = otr_pkg::STAT_BAD_ID;
               state_in = otr_pkg::ST_RESP;
            end else if (ovf_ff) begin
               st_in    = otr_pkg::STAT_TOO_LONG;
               state_in = otr_pkg::ST_RESP;
            end else begin
               state_in = otr_pkg::ST_FIND_RD;
            end
         end

         otr_pkg::ST_FIND_RD: begin
            if (s_ff[otr_pkg::SW-1]) begin
               found_in = 1'b0;
               state_in = otr_pkg::ST_FDONE;
            end else begin
               state_in = otr_pkg::ST_FIND_EV;
            end
         end

         otr_pkg::ST_FIND_EV: begin
            s_in     = s_ff - otr_pkg::SW'(1);
            state_in = otr_pkg::ST_FIND_RD;
            if ((tag[5:0] & otr_pkg::TAG_ID_MASK) == id_ff) begin
               if (fl == otr_pkg::FL_SINGLE) begin
                  found_in = 1'b1;
                  first_in = otr_pkg::AW'(s_ff);
                  n_in     = otr_pkg::SW'(1);
                  state_in = otr_pkg::ST_FDONE;
               end else if (fl == otr_pkg::FL_LAST) begin
                  t_in     = s_ff - otr_pkg::SW'(1);
                  n_in     = otr_pkg::SW'(1);
                  state_in = otr_pkg::ST_WALK_RD;
               end
            end
         end

         otr_pkg::ST_WALK_RD: begin
            if (t_ff[otr_pkg::SW-1]) begin
               found_in = 1'b0;
               state_in = otr_pkg::ST_FDONE;
            end else begin
               state_in = otr_pkg::ST_WALK_EV;
            end
         end

         otr_pkg::ST_WALK_EV: begin
            s_in     = t_ff - otr_pkg::SW'(1);
            state_in = otr_pkg::ST_FIND_RD;
            if (tag[5:0] == id_ff) begin
               n_in = n_ff + otr_pkg::SW'(1);
               if (fl == otr_pkg::FL_MIDDLE) begin
                  t_in     = t_ff - otr_pkg::SW'(1);
                  state_in = otr_pkg::ST_WALK_RD;
               end else if (fl == otr_pkg::FL_FIRST) begin
                  found_in = 1'b1;
                  first_in = otr_pkg::AW'(t_ff);
                  state_in = otr_pkg::ST_FDONE;
               end
            end
         end

         otr_pkg::ST_FDONE: begin
            b_in  = '0;
            bp_in = '0;
            sp_in = first_ff;
            s_in  = otr_pkg::SW'(otr_pkg::SLOT_COUNT - 1);
            if (!is_prog_ff) begin
               if (!found_ff) begin
                  st_in    = otr_pkg::STAT_NOT_FOUND;
                  state_in = otr_pkg::ST_RESP;
               end else begin
                  state_in = otr_pkg::ST_RD_INIT;
               end
            end else if (found_ff && otr_pkg::CW'(len_ff) <= n7) begin
               state_in = otr_pkg::ST_CMP_RD;
            end else begin
               state_in = otr_pkg::ST_TOP_RD;
            end
         end

         otr_pkg::ST_RD_INIT: begin
            cnt_in = otr_pkg::BW'(cmin);
            nb_in  = '0;
            buf_in = '0;
            if (cmin == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = otr_pkg::STAT_DATA;
               rsp_lo_in     = '0;
               rsp_hi_in     = '0;
               rsp_cnt_in    = '0;
               rsp_last_in   = 1'b1;
               state_in      = otr_pkg::ST_IDLE;
            end else begin
               state_in = otr_pkg::ST_RD_RD;
            end
         end

         otr_pkg::ST_RD_RD: begin
            state_in = otr_pkg::ST_RD_EV;
         end

         otr_pkg::ST_RD_EV: begin
            buf_nxt[nb_ff*8 +: 8] = ibyte;
            b_in  = b_ff + otr_pkg::BW'(1);
            nb_in = nb_ff + 4'd1;
            if (bp_ff == 3'd6) begin
               bp_in = '0;
               sp_in = sp_ff + otr_pkg::AW'(1);
            end else begin
               bp_in = bp_ff + 3'd1;
            end
            buf_in   = buf_nxt;
            state_in = otr_pkg::ST_RD_RD;
            if (nb_ff == 4'd13 || b_ff + otr_pkg::BW'(1) == cnt_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = otr_pkg::STAT_DATA;
               rsp_lo_in     = buf_nxt[55:0];
               rsp_hi_in     = buf_nxt[111:56];
               rsp_cnt_in    = nb_ff + 4'd1;
               rsp_last_in   = (b_ff + otr_pkg::BW'(1) == cnt_ff);
               buf_in        = '0;
               nb_in         = '0;
               if (b_ff + otr_pkg::BW'(1) == cnt_ff) begin
                  state_in = otr_pkg::ST_IDLE;
               end
            end
         end

         otr_pkg::ST_CMP_RD: begin
            if (otr_pkg::CW'(b_ff) == otr_pkg::CW'(len_ff)) begin
               st_in    = otr_pkg::STAT_PRESENT;
               state_in = otr_pkg::ST_RESP;
            end else begin
               state_in = otr_pkg::ST_CMP_EV;
            end
         end

         otr_pkg::ST_CMP_EV: begin
            if (pend_q != ibyte) begin
               state_in = otr_pkg::ST_TOP_RD;
            end else begin
               b_in = b_ff + otr_pkg::BW'(1);
               if (bp_ff == 3'd6) begin
                  bp_in = '0;
                  sp_in = sp_ff + otr_pkg::AW'(1);
               end else begin
                  bp_in = bp_ff + 3'd1;
               end
               state_in = otr_pkg::ST_CMP_RD;
            end
         end

         otr_pkg::ST_TOP_RD: begin
            if (s_ff[otr_pkg::SW-1]) begin
               start_in = '0;
               state_in = otr_pkg::ST_CHK;
            end else begin
               state_in = otr_pkg::ST_TOP_EV;
            end
         end

         otr_pkg::ST_TOP_EV: begin
            if (img_word != '1) begin
               start_in = s_ff + otr_pkg::SW'(1);
               state_in = otr_pkg::ST_CHK;
            end else begin
               s_in     = s_ff - otr_pkg::SW'(1);
               state_in = otr_pkg::ST_TOP_RD;
            end
         end

         otr_pkg::ST_CHK: begin
            k_in   = '0;
            b_in   = '0;
            bp_in  = '0;
            wrd_in = '0;
            if (otr_pkg::CW'(start_ff) + otr_pkg::CW'(pslots_ff) >
                otr_pkg::CW'(otr_pkg::SLOT_COUNT)) begin
               st_in    = otr_pkg::STAT_NO_SPACE;
               state_in = otr_pkg::ST_RESP;
            end else if (pslots_ff == '0) begin
               st_in    = otr_pkg::STAT_PROGRAMMED;
               state_in = otr_pkg::ST_RESP;
            end else begin
               state_in = otr_pkg::ST_WR_RD;
            end
         end

         otr_pkg::ST_WR_RD: begin
            state_in = otr_pkg::ST_WR_EV;
         end

         otr_pkg::ST_WR_EV: begin
            if (otr_pkg::CW'(b_ff) < otr_pkg::CW'(len_ff)) begin
               wbyte = pend_q;
            end
            wrd_in[bp_ff*8 +: 8] = wbyte;
            b_in = b_ff + otr_pkg::BW'(1);
            if (bp_ff == 3'd6) begin
               bp_in    = '0;
               state_in = otr_pkg::ST_WR_SLOT;
            end else begin
               bp_in    = bp_ff + 3'd1;
               state_in = otr_pkg::ST_WR_RD;
            end
         end

         otr_pkg::ST_WR_SLOT: begin
            img_we    = 1'b1;
            img_waddr = otr_pkg::AW'(otr_pkg::CW'(start_ff) + otr_pkg::CW'(k_ff));
            img_wdata = {ntag, wrd_ff};
            vld_in[otr_pkg::AW'(otr_pkg::CW'(start_ff) + otr_pkg::CW'(k_ff))] = 1'b1;
            k_in      = k_ff + otr_pkg::PSW'(1);
            wrd_in    = '0;
            if (k_ff + otr_pkg::PSW'(1) == pslots_ff) begin
               st_in    = otr_pkg::STAT_PROGRAMMED;
               state_in = otr_pkg::ST_RESP;
            end else begin
               state_in = otr_pkg::ST_WR_RD;
            end
         end

         otr_pkg::ST_RESP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = st_ff;
            rsp_lo_in     = '0;
            rsp_hi_in     = '0;
            rsp_cnt_in    = '0;
            rsp_last_in   = 1'b1;
            if (is_prog_ff) begin
               len_in    = '0;
               pos_in    = '0;
               pslots_in = '0;
               ovf_in    = 1'b0;
            end
            state_in = otr_pkg::ST_IDLE;
         end

         default: begin
            state_in = otr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= otr_pkg::ST_IDLE;
         len_ff       <= '0;
         pos_ff       <= '0;
         pslots_ff    <= '0;
         ovf_ff       <= 1'b0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         pslots_ff    <= pslots_in;
         ovf_ff       <= ovf_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_prog_ff    <= is_prog_in;
      id_ff         <= id_in;
      req_size_ff   <= req_size_in;
      cdata_ff      <= cdata_in;
      cbytes_ff     <= cbytes_in;
      clast_ff      <= clast_in;
      ai_ff         <= ai_in;
      s_ff          <= s_in;
      t_ff          <= t_in;
      n_ff          <= n_in;
      first_ff      <= first_in;
      found_ff      <= found_in;
      cnt_ff        <= cnt_in;
      b_ff          <= b_in;
      bp_ff         <= bp_in;
      sp_ff         <= sp_in;
      nb_ff         <= nb_in;
      buf_ff        <= buf_in;
      start_ff      <= start_in;
      k_ff          <= k_in;
      wrd_ff        <= wrd_in;
      st_ff         <= st_in;
      rd_vld_ff     <= vld_ff[img_raddr];
      rsp_status_ff <= rsp_status_in;
      rsp_lo_ff     <= rsp_lo_in;
      rsp_hi_ff     <= rsp_hi_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_payload_low  = rsp_lo_ff;
   assign rsp_payload_high = rsp_hi_ff;
   assign rsp_byte_count   = rsp_cnt_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ----- hw/rtl/otr_ram.sv -----
module otr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule

// ----- verif/tb_otp_tagged_record_store.sv -----
`timescale 1ns / 1ps

module tb_otp_tagged_record_store;

   typedef struct {
      otr_pkg::op_type op;
      logic [6:0]      idx;
      logic [63:0]     word;
      logic [5:0]      id;
      logic [9:0]      size;
      logic [55:0]     data;
      logic [2:0]      nbytes;
      logic            lastc;
   } request_type;

   typedef struct {
      request_type         rq;
      bit                  typed;
      otr_pkg::status_type st;
   } stim_row_type;

   typedef struct {
      otr_pkg::status_type status;
      logic [55:0]         lo;
      logic [55:0]         hi;
      logic [3:0]          cnt;
      logic                last;
   } outcome_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   logic [1:0]   req_opcode;
   logic [6:0]   req_slot_index;
   logic [63:0]  req_slot_word;
   logic [5:0]   req_record_id;
   logic [9:0]   req_request_size;
   logic [55:0]  req_chunk_data;
   logic [2:0]   req_chunk_bytes;
   logic         req_chunk_last;
   logic         rsp_valid;
   logic [2:0]   rsp_status;
   logic [55:0]  rsp_payload_low;
   logic [55:0]  rsp_payload_high;
   logic [3:0]   rsp_byte_count;
   logic         rsp_last;

   otp_tagged_record_store dut (.*);

   logic [63:0]  shadow_img [otr_pkg::SLOT_COUNT];
   logic [7:0]   shadow_pend [otr_pkg::MAX_RECORD_BYTES];
   int unsigned  pend_len;
   bit           pend_ovf;
   outcome_type  expected_q[$];
   int           errors;
   int           requests_sent;
   int           results_seen;
   stim_row_type directed[$];
   logic [7:0]   last_record[$];
   logic [5:0]   last_record_id;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      #20ms;
      $display("otp_tagged_record_store test failed");
      $finish;
   end

   function automatic logic [7:0] image_byte(int unsigned base, int unsigned i);
      int unsigned s;
      s = base + i / 7;
      if (s >= otr_pkg::SLOT_COUNT) return 8'h00;
      return shadow_img[s][8 * (i % 7) +: 8];
   endfunction

   function automatic int unsigned lookup_record(logic [5:0] id, output int unsigned base);
      int s;
      int t;
      int unsigned n;
      bit ok;
      logic [7:0] tg;
      base = 0;
      s = otr_pkg::SLOT_COUNT - 1;
      while (s >= 0) begin
         tg = shadow_img[s][63:56];
         if (tg[5:0] == id) begin
            if (tg[7:6] == otr_pkg::FL_SINGLE) begin
               base = s;
               return 1;
            end
            if (tg[7:6] == otr_pkg::FL_LAST) begin
               n = 1;
               ok = 0;
               t = s - 1;
               while (t >= 0) begin
                  tg = shadow_img[t][63:56];
                  if (tg[5:0] == id) begin
                     n++;
                     if (tg[7:6] == otr_pkg::FL_MIDDLE) begin
                        t--;
                        continue;
                     end
                     if (tg[7:6] == otr_pkg::FL_FIRST) ok = 1;
                  end
                  break;
               end
               if (t < 0) return 0;
               if (ok) begin
                  base = t;
                  return n;
               end
               s = t - 1;
               continue;
            end
         end
         s--;
      end
      return 0;
   endfunction

   function automatic otr_pkg::status_type commit_record(logic [5:0] id);
      int unsigned base, slots, i, k, top, need;
      logic [63:0] w;
      logic [7:0]  tag;
      if (id > otr_pkg::ID_LIMIT) return otr_pkg::STAT_BAD_ID;
      if (pend_ovf) return otr_pkg::STAT_TOO_LONG;
      slots = lookup_record(id, base);
      if (slots != 0 && pend_len <= slots * 7) begin
         for (i = 0; i < pend_len; i++)
            if (shadow_pend[i] != image_byte(base, i)) break;
         if (i == pend_len) return otr_pkg::STAT_PRESENT;
      end
      top = 0;
      for (int s = otr_pkg::SLOT_COUNT - 1; s >= 0; s--) begin
         if (shadow_img[s] != '1) begin
            top = s + 1;
            break;
         end
      end
      need = (pend_len + 6) / 7;
      if (top + need > otr_pkg::SLOT_COUNT) return otr_pkg::STAT_NO_SPACE;
      for (k = 0; k < need; k++) begin
         w = '0;
         tag = {2'b00, id};
         for (i = 0; i < 7; i++)
            if (k * 7 + i < pend_len) w[8 * i +: 8] = shadow_pend[k * 7 + i];
         if (need > 1) begin
            if (k != 0) tag = tag | otr_pkg::TAG_NOT_FIRST;
            if (k != need - 1) tag = tag | otr_pkg::TAG_NOT_LAST;
         end
         w[63:56] = tag;
         shadow_img[top + k] = w;
      end
      return otr_pkg::STAT_PROGRAMMED;
   endfunction

   task automatic model_request(request_type r, ref outcome_type res[$]);
      int unsigned base, slots, count, nres, b;
      outcome_type o;
      res.delete();
      o = '{otr_pkg::STAT_DATA, '0, '0, '0, 1'b1};
      case (r.op)
         otr_pkg::OP_LOAD: begin
            shadow_img[r.idx] = r.word;
         end
         otr_pkg::OP_READ: begin
            if (r.id > otr_pkg::ID_LIMIT) begin
               o.status = otr_pkg::STAT_BAD_ID;
               res.push_back(o);
            end else begin
               slots = lookup_record(r.id, base);
               if (slots == 0) begin
                  o.status = otr_pkg::STAT_NOT_FOUND;
                  res.push_back(o);
               end else begin
                  count = r.size;
                  if (count > slots * 7) count = slots * 7;
                  if (count > otr_pkg::MAX_RESULTS * 14) count = otr_pkg::MAX_RESULTS * 14;
                  nres = (count == 0) ? 1 : (count + 13) / 14;
                  for (int unsigned q = 0; q < nres; q++) begin
                     o = '{otr_pkg::STAT_DATA, '0, '0, '0, (q == nres - 1)};
                     for (int unsigned i = 0; i < 14; i++) begin
                        b = q * 14 + i;
                        if (b >= count) break;
                        if (i < 7) o.lo[8 * i +: 8] = image_byte(base, b);
                        else o.hi[8 * (i - 7) +: 8] = image_byte(base, b);
                        o.cnt++;
                     end
                     res.push_back(o);
                  end
               end
            end
         end
         otr_pkg::OP_PROGRAM: begin
            for (int i = 0; i < r.nbytes; i++) begin
               if (pend_len < otr_pkg::MAX_RECORD_BYTES) begin
                  shadow_pend[pend_len] = r.data[8 * i +: 8];
                  pend_len++;
               end else begin
                  pend_ovf = 1;
               end
            end
            if (r.lastc) begin
               o.status = commit_record(r.id);
               pend_len = 0;
               pend_ovf = 0;
               res.push_back(o);
            end
         end
         default: ;
      endcase
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic issue(request_type r, bit typed = 1'b0,
                        otr_pkg::status_type ts = otr_pkg::STAT_DATA);
      outcome_type res[$];
      while (busy) @(negedge clock);
      req_opcode = r.op;
      req_slot_index = r.idx;
      req_slot_word = r.word;
      req_record_id = r.id;
      req_request_size = r.size;
      req_chunk_data = r.data;
      req_chunk_bytes = r.nbytes;
      req_chunk_last = r.lastc;
      start = 1'b1;
      @(posedge clock);
      model_request(r, res);
      if (typed) begin
         res.delete();
         res.push_back('{ts, '0, '0, '0, 1'b1});
      end
      foreach (res[i]) expected_q.push_back(res[i]);
      requests_sent++;
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic idle_gap();
      int g;
      g = $urandom_range(0, 99);
      if (g < 60) g = 0;
      else if (g < 95) g = $urandom_range(1, 4);
      else g = $urandom_range(20, 80);
      repeat (g) @(negedge clock);
   endtask

   task automatic drain();
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic erase_image();
      request_type r;
      drain();
      for (int s = 0; s < otr_pkg::SLOT_COUNT; s++) begin
         if (shadow_img[s] != '1) begin
            r = '{otr_pkg::OP_LOAD, 7'(s), '1, '0, '0, '0, '0, 1'b0};
            issue(r);
            idle_gap();
         end
      end
   endtask

   function automatic stim_row_type mk(otr_pkg::op_type op, int idx, logic [63:0] word,
                                       int id, int size, logic [55:0] data,
                                       int nb, int lc, int typed = 0,
                                       otr_pkg::status_type ts = otr_pkg::STAT_DATA);
      stim_row_type row;
      row.rq = '{op, 7'(idx), word, 6'(id), 10'(size), data, 3'(nb), (lc != 0)};
      row.typed = (typed != 0);
      row.st = ts;
      return row;
   endfunction

   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result status %0d", $time, rsp_status);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_payload_low !== e.lo) begin
               $display("%0t: payload_low expected %h actual %h", $time, e.lo,
                        rsp_payload_low);
               errors++;
            end
            if (rsp_payload_high !== e.hi) begin
               $display("%0t: payload_high expected %h actual %h", $time, e.hi,
                        rsp_payload_high);
               errors++;
            end
            if (rsp_byte_count !== e.cnt) begin
               $display("%0t: byte_count expected %0d actual %0d", $time, e.cnt,
                        rsp_byte_count);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $display("%0t: last expected %0d actual %0d", $time, e.last, rsp_last);
               errors++;
            end
         end
      end
   end

   initial begin
      request_type r;
      int kind, chunks, sent;
      logic [63:0] w;
      logic [7:0] tag;

      reset = 1'b1;
      start = 1'b0;
      req_opcode = '0;
      req_slot_index = '0;
      req_slot_word = '0;
      req_record_id = '0;
      req_request_size = '0;
      req_chunk_data = '0;
      req_chunk_bytes = '0;
      req_chunk_last = 1'b0;
      errors = 0;
      requests_sent = 0;
      results_seen = 0;
      pend_len = 0;
      pend_ovf = 0;
      last_record_id = '0;
      foreach (shadow_img[i]) shadow_img[i] = '1;
      foreach (shadow_pend[i]) shadow_pend[i] = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      directed.push_back(mk(otr_pkg::OP_READ, 0, '0, 5, 10, '0, 0, 0, 1,
                            otr_pkg::STAT_NOT_FOUND));
      directed.push_back(mk(otr_pkg::OP_READ, 0, '0, 63, 10, '0, 0, 0, 1,
                            otr_pkg::STAT_BAD_ID));
      directed.push_back(mk(otr_pkg::OP_PROGRAM, 0, '0, 63, 0, '0, 0, 1, 1,
                            otr_pkg::STAT_BAD_ID));
      directed.push_back(mk(otr_pkg::OP_PROGRAM, 0, '0, 0, 0, '1, 7, 0));
      directed.push_back(mk(otr_pkg::OP_PROGRAM, 0, '0, 0, 0, 56'h112233, 3, 1, 1,
                            otr_pkg::STAT_PROGRAMMED));
      directed.push_back(mk(otr_pkg::OP_READ, 0, '0, 0, 896, '0, 0, 0));
      directed.push_back(mk(otr_pkg::OP_READ, 0, '0, 0, 0, '0, 0, 0));
      directed.push_back(mk(otr_pkg::OP_PROGRAM, 0, '0, 0, 0, '1, 7, 0));
      directed.push_back(mk(otr_pkg::OP_PROGRAM, 0, '0, 0, 0, 56'h112233, 3, 1));
      directed.push_back(mk(otr_pkg::OP_PROGRAM, 0, '0, 0, 0, '0, 0, 1));
      directed.push_back(mk(otr_pkg::OP_PROGRAM, 0, '0, 62, 0, '0, 0, 1));
      directed.push_back(mk(otr_pkg::OP_NONE, 5, '1, 1, 5, '1, 7, 1));
      directed.push_back(mk(otr_pkg::OP_LOAD, 8, {8'h43, 56'h0a0b0c0d0e0f10}, 0, 0, '0, 0, 0));
      directed.push_back(mk(otr_pkg::OP_LOAD, 9, {8'hc3, 56'h11121314151617}, 0, 0, '0, 0, 0));
      directed.push_back(mk(otr_pkg::OP_LOAD, 10, {8'h83, 56'h18191a1b1c1d1e}, 0, 0, '0, 0, 0));
      directed.push_back(mk(otr_pkg::OP_READ, 0, '0, 3, 21, '0, 0, 0));
      directed.push_back(mk(otr_pkg::OP_LOAD, 12, {8'h83, 56'hdeadbeef00}, 0, 0, '0, 0, 0));
      directed.push_back(mk(otr_pkg::OP_LOAD, 11, {8'h05, 56'h1}, 0, 0, '0, 0, 0));
      directed.push_back(mk(otr_pkg::OP_READ, 0, '0, 3, 30, '0, 0, 0));
      directed.push_back(mk(otr_pkg::OP_LOAD, 127, 64'h0, 0, 0, '0, 0, 0));
      directed.push_back(mk(otr_pkg::OP_PROGRAM, 0, '0, 1, 0, 56'h5a, 1, 1, 1,
                            otr_pkg::STAT_NO_SPACE));
      directed.push_back(mk(otr_pkg::OP_READ, 0, '0, 0, 7, '0, 0, 0));
      directed.push_back(mk(otr_pkg::OP_LOAD, 127, '1, 0, 0, '0, 0, 0));
      foreach (directed[i]) begin
         issue(directed[i].rq, directed[i].typed, directed[i].st);
         idle_gap();
      end

      // A record one byte past the buffer limit must be refused as too long.
      for (int i = 0; i < otr_pkg::MAX_RECORD_BYTES / 7; i++) begin
         r = '{otr_pkg::OP_PROGRAM, '0, '0, 6'd4, '0, 56'({$urandom, $urandom}), 3'd7, 1'b0};
         issue(r);
      end
      r = '{otr_pkg::OP_PROGRAM, '0, '0, 6'd4, '0, 56'h77, 3'd1, 1'b1};
      issue(r, 1'b1, otr_pkg::STAT_TOO_LONG);
      erase_image();

      sent = 0;
      while (requests_sent < 280) begin
         if (sent % 40 == 39) erase_image();
         sent++;
         kind = $urandom_range(0, 99);
         if (kind < 20) begin
            tag = {2'($urandom_range(0, 3)), 6'($urandom_range(0, 6))};
            if ($urandom_range(0, 9) == 0) tag = 8'($urandom);
            w = {tag, 56'({$urandom, $urandom})};
            if ($urandom_range(0, 9) == 0) w = '1;
            r = '{otr_pkg::OP_LOAD, 7'($urandom_range(0, 40)), w, '0, '0, '0, '0, 1'b0};
            if ($urandom_range(0, 9) == 0) r.idx = 7'($urandom);
            issue(r);
         end else if (kind < 50) begin
            r = '{otr_pkg::OP_READ, 7'($urandom), {$urandom, $urandom},
                  6'($urandom_range(0, 7)), 10'($urandom_range(0, 40)),
                  56'({$urandom, $urandom}), 3'($urandom), 1'($urandom)};
            if ($urandom_range(0, 9) == 0) r.id = 6'($urandom);
            if ($urandom_range(0, 9) == 0) r.size = 10'($urandom_range(0, 1023));
            issue(r);
         end else if (kind < 58 && last_record.size() != 0) begin
            for (int i = 0; i < last_record.size(); i += 7) begin
               r = '{otr_pkg::OP_PROGRAM, '0, '0, last_record_id, '0, '0, '0, 1'b0};
               for (int j = 0; j < 7 && i + j < last_record.size(); j++) begin
                  r.data[8 * j +: 8] = last_record[i + j];
                  r.nbytes++;
               end
               r.lastc = (i + 7 >= last_record.size());
               issue(r);
               idle_gap();
            end
         end else if (kind < 97) begin
            chunks = $urandom_range(1, 4);
            last_record.delete();
            last_record_id = 6'($urandom_range(0, 7));
            if ($urandom_range(0, 19) == 0) last_record_id = 6'($urandom);
            for (int c = 0; c < chunks; c++) begin
               r = '{otr_pkg::OP_PROGRAM, 7'($urandom), {$urandom, $urandom}, last_record_id,
                     10'($urandom), 56'({$urandom, $urandom}), 3'($urandom_range(0, 7)),
                     (c == chunks - 1)};
               if (c != chunks - 1 && $urandom_range(0, 3) == 0) r.id = 6'($urandom);
               for (int j = 0; j < r.nbytes; j++) last_record.push_back(r.data[8 * j +: 8]);
               issue(r);
               idle_gap();
            end
         end else begin
            r = '{otr_pkg::OP_NONE, 7'($urandom), {$urandom, $urandom}, 6'($urandom),
                  10'($urandom), 56'({$urandom, $urandom}), 3'($urandom), 1'($urandom)};
            issue(r);
         end
         idle_gap();
      end

      drain();
      repeat (400) @(negedge clock);
      $display("Covered %0d requests (loads, reads, programs, ignored codes) and %0d results,",
               requests_sent, results_seen);
      $display("including chains, broken chains, overflow, full image and duplicate records.");
      if (errors == 0 && expected_q.size() == 0) begin
         $display("otp_tagged_record_store test passed");
      end else begin
         $display("otp_tagged_record_store test failed");
      end
      $finish;
   end

endmodule
